// File: hw/rtl/dcs_pkg.sv
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared types and constants for the distributed-clock PI sync unit.
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STAMP_W  = 64;
  localparam int unsigned EXT_W    = 63;
  localparam int unsigned OFFSET_W = 28;
  localparam int unsigned DELTA_W  = 33;
  localparam int unsigned STEP_W   = 6;

  localparam logic [TIME_W-1:0] CYCLE_TIME_RST = 32'd1000000;
  localparam logic [TIME_W-1:0] SHIFT_TIME_RST = 32'd50000;

  // reciprocal multipliers: x/100 = (x*M100)>>37, x/20 = (x*M20)>>36, x < 2^32
  localparam logic [TIME_W-1:0] M100 = 32'h51EB_851F;
  localparam logic [TIME_W-1:0] M20  = 32'hCCCC_CCCD;

  localparam logic CFG_CYCLE_TIME = 1'b0;
  localparam logic CFG_SHIFT_TIME = 1'b1;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic fold;
    logic mul_d;
    logic mul_i;
    logic finish;
  } dcs_cmd_t;

  typedef struct packed {
    logic div_last;
  } dcs_sts_t;

endpackage

// File: hw/rtl/dcs_dp.sv
// ----------------------------------------------------------------------------
// dcs_dp
// Datapath: timestamp extension, bit-serial 64/32 remainder, integral
// counter and reciprocal-multiply offset computation.
// ----------------------------------------------------------------------------
module dcs_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [dcs_pkg::TIME_W-1:0]        cfg_wdata,
  input  logic [dcs_pkg::TIME_W-1:0]        in_dc_time_low,
  input  dcs_pkg::dcs_cmd_t                 cmd,
  output dcs_pkg::dcs_sts_t                 sts,
  output logic signed [dcs_pkg::OFFSET_W-1:0] out_offset_ns,
  output logic [dcs_pkg::EXT_W-1:0]         out_extended_time
);
  import dcs_pkg::*;

  logic [TIME_W-1:0]         cycle_time_r;
  logic [TIME_W-1:0]         shift_time_r;
  logic [TIME_W-1:0]         last_r;
  logic [STAMP_W-1:0]        stamp_r;
  logic signed [TIME_W-1:0]  integ_r;
  logic [STAMP_W-1:0]        quo_r;
  logic [TIME_W-1:0]         rem_r;
  logic [STEP_W-1:0]         cnt_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic [STAMP_W-1:0]        prod_r;
  logic [26:0]               qd_r;
  logic signed [OFFSET_W-1:0] offset_r;
  logic [EXT_W-1:0]          ext_r;

  logic [TIME_W-1:0]         hi_nxt;
  logic [TIME_W:0]           trial;
  logic [TIME_W:0]           trial_sub;
  logic signed [DELTA_W-1:0] delta_nxt;
  logic signed [TIME_W-1:0]  integ_nxt;
  logic [DELTA_W-1:0]        abs_d_full;
  logic [TIME_W-1:0]         abs_d;
  logic [TIME_W-1:0]         abs_i;
  logic [TIME_W-1:0]         mul_a;
  logic [TIME_W-1:0]         mul_b;
  logic [OFFSET_W:0]         term_d;
  logic [OFFSET_W:0]         term_i;
  logic [OFFSET_W:0]         offset_sum;

  assign hi_nxt    = stamp_r[STAMP_W-1:TIME_W] +
                     ((in_dc_time_low < last_r) ? 32'd1 : 32'd0);
  assign trial     = {rem_r, quo_r[STAMP_W-1]};
  assign trial_sub = trial - {1'b0, cycle_time_r};

  always_comb begin
    if (cycle_time_r == '0) begin
      delta_nxt = '0;
    end else if (rem_r > (cycle_time_r >> 1)) begin
      delta_nxt = $signed({1'b0, rem_r} - {1'b0, cycle_time_r});
    end else begin
      delta_nxt = $signed({1'b0, rem_r});
    end
    integ_nxt = integ_r;
    if (delta_nxt > 0 && integ_r != 32'sh7FFF_FFFF) begin
      integ_nxt = integ_r + 32'sd1;
    end else if (delta_nxt < 0 && integ_r != 32'sh8000_0000) begin
      integ_nxt = integ_r - 32'sd1;
    end
  end

  assign abs_d_full = delta_r[DELTA_W-1] ? (-delta_r) : delta_r;
  assign abs_d      = abs_d_full[TIME_W-1:0];
  assign abs_i      = integ_r[TIME_W-1] ? (-integ_r) : integ_r;
  assign mul_a      = cmd.mul_i ? abs_i : abs_d;
  assign mul_b      = cmd.mul_i ? M20 : M100;

  assign term_d     = delta_r[DELTA_W-1] ? {2'b00, qd_r} : -{2'b00, qd_r};
  assign term_i     = integ_r[TIME_W-1] ? {1'b0, prod_r[63:36]} : -{1'b0, prod_r[63:36]};
  assign offset_sum = term_d + term_i;

  assign sts.div_last = (cnt_r == '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_time_r <= CYCLE_TIME_RST;
      shift_time_r <= SHIFT_TIME_RST;
      last_r       <= '0;
      stamp_r      <= '0;
      integ_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CYCLE_TIME: cycle_time_r <= cfg_wdata;
          CFG_SHIFT_TIME: shift_time_r <= cfg_wdata;
          default:        ;
        endcase
      end
      if (cmd.load) begin
        stamp_r <= {hi_nxt, in_dc_time_low};
        last_r  <= in_dc_time_low;
      end
      if (cmd.fold) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quo_r <= stamp_r + {32'd0, shift_time_r};
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.step) begin
      quo_r <= {quo_r[STAMP_W-2:0], 1'b0};
      rem_r <= trial_sub[TIME_W] ? trial[TIME_W-1:0] : trial_sub[TIME_W-1:0];
      cnt_r <= cnt_r + 6'd1;
    end
    if (cmd.fold) begin
      delta_r <= delta_nxt;
    end
    if (cmd.mul_d || cmd.mul_i) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.mul_i) begin
      qd_r <= prod_r[63:37];
    end
    if (cmd.finish) begin
      offset_r <= $signed(offset_sum[OFFSET_W-1:0]);
      ext_r    <= stamp_r[EXT_W-1:0];
    end
  end

  assign out_offset_ns     = offset_r;
  assign out_extended_time = ext_r;

endmodule

// File: hw/rtl/dcs_ctrl.sv
// ----------------------------------------------------------------------------
// dcs_ctrl
// Sequencer: accepts a beat, runs the remainder loop and the offset steps,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module dcs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  dcs_pkg::dcs_sts_t  sts,
  output dcs_pkg::dcs_cmd_t  cmd
);
  import dcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FOLD,
    S_MUL_D,
    S_MUL_I,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.prep   = (state_r == S_PREP);
    cmd.step   = (state_r == S_DIV);
    cmd.fold   = (state_r == S_FOLD);
    cmd.mul_d  = (state_r == S_MUL_D);
    cmd.mul_i  = (state_r == S_MUL_I);
    cmd.finish = (state_r == S_FIN) && out_free;

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_DIV;
      S_DIV:   if (sts.div_last) state_nxt = S_FOLD;
      S_FOLD:  state_nxt = S_MUL_D;
      S_MUL_D: state_nxt = S_MUL_I;
      S_MUL_I: state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/dc_clock_sync_pi_unit.sv
// ----------------------------------------------------------------------------
// dc_clock_sync_pi_unit
// PI phase-lock controller for a 32-bit distributed clock.
//
// Input channel: one beat per control cycle carries in_dc_time_low. The
// reading is extended into a 64-bit timestamp past each wrap.
// Result channel: one beat per input beat, out_offset_ns (signed correction)
// and out_extended_time (low 63 bits of the timestamp).
// Config port: cfg_index 0 is cycle_time, 1 is shift_time; write only while
// idle.
// Steps: prep, the bit-serial 64-bit remainder, fold, two multiply steps
// and finish, which loads the output register.
// Flow: in_stall is high while an item is in work, so a new beat is taken
// only once the last item is finished. A result waiting under out_stall
// does not block the next input.
// Reset: timestamp, last reading and integral clear; cycle_time goes to
// 1000000 and shift_time to 50000; no result pending.
// A stalled result holds until taken; a finished item waits on it.
// ----------------------------------------------------------------------------
module dc_clock_sync_pi_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [dcs_pkg::TIME_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dcs_pkg::TIME_W-1:0]           in_dc_time_low,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dcs_pkg::OFFSET_W-1:0]  out_offset_ns,
  output logic [dcs_pkg::EXT_W-1:0]            out_extended_time
);
  import dcs_pkg::*;

  dcs_cmd_t cmd;
  dcs_sts_t sts;

  dcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dcs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_dc_time_low    (in_dc_time_low),
    .cmd               (cmd),
    .sts               (sts),
    .out_offset_ns     (out_offset_ns),
    .out_extended_time (out_extended_time)
  );

endmodule
